// ----- hw/rtl/address_pool_allocator_assert.svh -----
// assertion helpers shared by the allocator modules
// both expect clk_i in the enclosing module, APA_ASSERT also rst_ni
`ifndef ADDRESS_POOL_ALLOCATOR_ASSERT_SVH
`define ADDRESS_POOL_ALLOCATOR_ASSERT_SVH

// checked only outside reset
`define APA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("allocator check failed");

// checked on every edge, reset included
`define APA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("allocator check failed");

`endif

// ----- hw/rtl/apa_pkg.sv -----
package apa_pkg;

  localparam int MAX_HOST_BITS = 8;
  localparam int MIN_HOST_BITS = 2;
  localparam int HOST_W        = MAX_HOST_BITS;
  localparam int MAP_DEPTH     = 1 << MAX_HOST_BITS;
  localparam int WORD_W        = 32;
  localparam int BIT_W         = 5;
  localparam int MAP_WORDS     = (MAP_DEPTH > WORD_W) ? MAP_DEPTH / WORD_W : 1;
  localparam int WIDX_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int STEP_W        = WIDX_W + 1;
  localparam int CNT_W         = MAX_HOST_BITS + 1;
  localparam int EB_W          = $clog2(MAX_HOST_BITS + 1);
  localparam int CFG_W         = 4;
  localparam int ADDR_W        = 32;

  localparam logic [CFG_W-1:0] HOST_BITS_RESET = CFG_W'(8);

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } apa_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } apa_state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] addr;
  } apa_in_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] granted_addr;
    logic [CNT_W-1:0]  free_count;
  } apa_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic push;
  } apa_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic pool_empty;
    logic scan_done;
    logic out_ready;
  } apa_sts_t;

  function automatic logic [EB_W-1:0] eff_bits(input logic [CFG_W-1:0] hb);
    logic [EB_W-1:0] b;
    if (hb < CFG_W'(MIN_HOST_BITS)) begin
      b = EB_W'(MIN_HOST_BITS);
    end else if (hb > CFG_W'(MAX_HOST_BITS)) begin
      b = EB_W'(MAX_HOST_BITS);
    end else begin
      b = EB_W'(hb);
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/apa_ctrl.sv -----
`include "address_pool_allocator_assert.svh"

module apa_ctrl import apa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  apa_sts_t sts_i,
  output apa_ctl_t ctl_o
);

  apa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.is_alloc && !sts_i.pool_empty) state_d = ST_SCAN;
        else state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_ready) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ctl_o.load = in_valid_i;
      end
      ST_EXEC: begin
        if (sts_i.is_alloc && !sts_i.pool_empty) ctl_o.scan_start = 1'b1;
        else ctl_o.exec = 1'b1;
      end
      ST_SCAN: begin
        ctl_o.scan_step = 1'b1;
      end
      ST_DONE: begin
        ctl_o.push = sts_i.out_ready;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

  `APA_ASSERT(a_accept_exec, (in_valid_i && !in_stall_o) |=> (state_q == ST_EXEC))
  `APA_ASSERT(a_scan_exit, (state_q == ST_SCAN && sts_i.scan_done) |=> (state_q == ST_DONE))
  `APA_ASSERT_ALWAYS(a_one_cmd, $onehot0(ctl_o))

endmodule

// ----- hw/rtl/apa_dp.sv -----
`include "address_pool_allocator_assert.svh"

module apa_dp import apa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  apa_in_t          in_data_i,
  input  apa_ctl_t         ctl_i,
  output apa_sts_t         sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output apa_out_t         out_data_o
);

  // map cleared with host all-zeros, all-ones and all-ones minus one taken
  function automatic logic [MAP_DEPTH-1:0] reserve_map(input logic [EB_W-1:0] eb);
    logic [MAP_DEPTH-1:0] m;
    logic [HOST_W-1:0]    top;
    top = HOST_W'((CNT_W'(1) << eb) - CNT_W'(1));
    m = '0;
    m[0] = 1'b1;
    m[top] = 1'b1;
    m[top - HOST_W'(1)] = 1'b1;
    return m;
  endfunction

  function automatic logic [CNT_W-1:0] reserve_cnt(input logic [EB_W-1:0] eb);
    return (CNT_W'(1) << eb) - CNT_W'(3);
  endfunction

  logic [CFG_W-1:0]     host_bits_q;
  logic [MAP_DEPTH-1:0] map_q;
  logic [CNT_W-1:0]     free_q;
  apa_in_t              item_q;
  logic [STEP_W-1:0]    step_q;
  logic                 res_full_q;
  logic [ADDR_W-1:0]    res_addr_q;
  logic                 out_valid_q;
  apa_out_t             out_q;

  logic [EB_W-1:0]   eb;
  logic [CNT_W-1:0]  pool_n;
  logic [HOST_W-1:0] host_mask;
  logic [ADDR_W-1:0] addr_mask;
  logic [HOST_W-1:0] host;
  logic [WIDX_W-1:0] word_mask;
  logic [WIDX_W-1:0] start_w;
  logic [BIT_W-1:0]  start_b;
  logic [STEP_W-1:0] last_step;
  logic [WIDX_W-1:0] scan_w;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] valid_bits;
  logic [WORD_W-1:0] low_cut;
  logic [WORD_W-1:0] cand;
  logic              found;
  logic [BIT_W-1:0]  hit_b;
  logic [HOST_W-1:0] hit_host;
  logic              scan_done;

  assign eb        = eff_bits(host_bits_q);
  assign pool_n    = CNT_W'(1) << eb;
  assign host_mask = HOST_W'(pool_n - CNT_W'(1));
  assign addr_mask = ADDR_W'(host_mask);
  assign host      = HOST_W'(item_q.addr) & host_mask;
  assign word_mask = WIDX_W'(host_mask >> BIT_W);
  assign start_w   = WIDX_W'(host >> BIT_W);
  assign start_b   = BIT_W'(host);
  assign last_step = STEP_W'(word_mask) + STEP_W'(1);

  // step 0 takes the start word from the proposed bit up, the last step
  // revisits it whole to cover the bits below after the wrap
  assign scan_w     = (start_w + WIDX_W'(step_q)) & word_mask;
  assign word       = map_q[{scan_w, {BIT_W{1'b0}}} +: WORD_W];
  assign valid_bits = WORD_W'(((WORD_W + 1)'(1) << pool_n) - (WORD_W + 1)'(1));
  assign low_cut    = (step_q == '0) ? ({WORD_W{1'b1}} << start_b) : {WORD_W{1'b1}};
  assign cand       = ~word & valid_bits & low_cut;
  assign found      = |cand;

  always_comb begin
    hit_b = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) hit_b = BIT_W'(i);
    end
  end

  assign hit_host  = HOST_W'({scan_w, hit_b});
  assign scan_done = found || (step_q == last_step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_bits_q <= HOST_BITS_RESET;
      map_q       <= reserve_map(eff_bits(HOST_BITS_RESET));
      free_q      <= reserve_cnt(eff_bits(HOST_BITS_RESET));
    end else if (cfg_we_i) begin
      host_bits_q <= cfg_wdata_i;
      map_q       <= reserve_map(eff_bits(cfg_wdata_i));
      free_q      <= reserve_cnt(eff_bits(cfg_wdata_i));
    end else if (ctl_i.exec) begin
      case (item_q.cmd)
        CMD_FREE: begin
          if (map_q[host]) begin
            map_q[host] <= 1'b0;
            free_q      <= free_q + CNT_W'(1);
          end
        end
        CMD_INIT: begin
          map_q  <= reserve_map(eb);
          free_q <= reserve_cnt(eb);
        end
        default: begin
          free_q <= free_q;
        end
      endcase
    end else if (ctl_i.scan_step && found) begin
      map_q[hit_host] <= 1'b1;
      free_q          <= free_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.scan_start) step_q <= '0;
      else if (ctl_i.scan_step && !scan_done) step_q <= step_q + STEP_W'(1);
      if (ctl_i.push) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) item_q <= in_data_i;
    if (ctl_i.exec) begin
      // only an allocate on an empty pool reaches here as an allocate
      res_full_q <= (item_q.cmd == CMD_ALLOC) ? STATUS_FULL : STATUS_OK;
      res_addr_q <= '0;
    end else if (ctl_i.scan_step && found) begin
      res_full_q <= STATUS_OK;
      res_addr_q <= (item_q.addr & ~addr_mask) | ADDR_W'(hit_host);
    end else if (ctl_i.scan_step && scan_done) begin
      res_full_q <= STATUS_FULL;
      res_addr_q <= '0;
    end
    if (ctl_i.push) begin
      out_q.status       <= res_full_q;
      out_q.granted_addr <= res_addr_q;
      out_q.free_count   <= free_q;
    end
  end

  assign sts_o.is_alloc   = (item_q.cmd == CMD_ALLOC);
  assign sts_o.pool_empty = (free_q == '0);
  assign sts_o.scan_done  = scan_done;
  assign sts_o.out_ready  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `APA_ASSERT(a_free_bound, free_q <= pool_n)
  `APA_ASSERT(a_push_valid, ctl_i.push |=> out_valid_q)
  `APA_ASSERT(a_out_hold, (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))

endmodule

// ----- hw/rtl/address_pool_allocator.sv -----
// one item at a time; free, init and unknown commands and an allocate on an empty pool go
// from accept through EXEC to DONE, any other allocate adds the word scan in SCAN
// the word scan reads one 32-bit map word per cycle, up to pool/32 + 1 words
// (9 at 256 hosts, 2 at 32 hosts or fewer), then the result is pushed
// a new item is taken only after the last result has been pushed to the output
// reset: host_bits 8, map clear except hosts 0, 254 and 255, free count 253
module address_pool_allocator import apa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  apa_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output apa_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  apa_ctl_t ctl;
  apa_sts_t sts;

  apa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  apa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
